@@ design/vpsr_pkg.sv @@
// Shared types for the vector path segment resolver.
// Holds the command and segment codes and the input and result item layouts.
`default_nettype none
package vpsr_pkg;

	// Field widths fixed by the stream layout
	localparam int FIELD_BITS = 32;
	localparam int TDATA_BITS = 6 * FIELD_BITS;
	localparam int S_TUSER_BITS = 6;
	localparam int M_TUSER_BITS = 2;

	// Path command codes; code 7 is handled as close
	typedef enum logic [2:0] {
		CMD_MOVE   = 3'd0,
		CMD_LINE   = 3'd1,
		CMD_HORIZ  = 3'd2,
		CMD_VERT   = 3'd3,
		CMD_CUBIC  = 3'd4,
		CMD_SMOOTH = 3'd5,
		CMD_CLOSE  = 3'd6
	} cmd_t;

	// Result segment kinds
	typedef enum logic [1:0] {
		SEG_MOVE  = 2'd0,
		SEG_LINE  = 2'd1,
		SEG_CUBIC = 2'd2,
		SEG_CLOSE = 2'd3
	} seg_kind_t;

	typedef logic signed [FIELD_BITS-1:0] field_t;

	// One tokenized coordinate group
	typedef struct packed {
		cmd_t   cmd;
		logic   relative;
		logic   first_of_command;
		logic   path_start;
		field_t ctrl_one_x;
		field_t ctrl_one_y;
		field_t ctrl_two_x;
		field_t ctrl_two_y;
		field_t end_x;
		field_t end_y;
	} in_item_t;

	// One absolute segment
	typedef struct packed {
		seg_kind_t seg_kind;
		field_t    abs_c1_x;
		field_t    abs_c1_y;
		field_t    abs_c2_x;
		field_t    abs_c2_y;
		field_t    abs_end_x;
		field_t    abs_end_y;
	} out_item_t;

endpackage
`default_nettype wire

@@ design/vector_path_segment_resolver_top.sv @@
// Top level of the vector path segment resolver: input register, path state,
// result register and stream handshakes. Depends on vpsr_pkg and vpsr_resolve.
//
// Usage:
//   Slave channel s_*: one tokenized coordinate group per item. s_tuser carries
//   the command and flags, s_tdata the six coordinates (Q16.16, signed).
//   Master channel m_*: one absolute segment per item. m_tuser carries the
//   segment kind, m_tdata the six absolute coordinates.
//   An accepted item moves from the input register to the result register and
//   then shows on m_*; a low m_tready with a full result register holds it.
//   Throughput: one item per cycle while m_tready is high. The current point,
//   last control point, curve flag and subpath start are updated by one
//   adder/mux level as each item moves from the input to the result register.
//   Stall: while m_tready is low a full result register holds; the input
//   register still takes one more item, then s_tready drops.
//   Reset: arst_n low empties both registers and zeroes all path state.
`default_nettype none
module vector_path_segment_resolver_top #(
	parameter int COORD_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// ctrl_one_x, ctrl_one_y, ctrl_two_x, ctrl_two_y, end_x, end_y (32 each)
	input  logic [191:0] s_tdata,
	// cmd[2:0], relative[3], first_of_command[4], path_start[5]
	input  logic [5:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// abs_c1_x, abs_c1_y, abs_c2_x, abs_c2_y, abs_end_x, abs_end_y (32 each)
	output logic [191:0] m_tdata,
	// seg_kind[1:0]
	output logic [1:0]   m_tuser
);

	typedef logic signed [COORD_BITS-1:0] coord_t;

	vpsr_pkg::in_item_t  item_in;
	vpsr_pkg::in_item_t  item_s1;
	vpsr_pkg::out_item_t res_c;
	vpsr_pkg::out_item_t res_s2;
	logic valid_s1, valid_s2;
	logic s2_load, adv, s_take;

	coord_t cur_x_q, cur_y_q, last_ctrl_x_q, last_ctrl_y_q, sub_x_q, sub_y_q;
	logic   prev_curve_q;
	coord_t n_cur_x, n_cur_y, n_lcx, n_lcy, n_sub_x, n_sub_y;
	logic   n_prev_curve;

	// Unpack the slave item
	always_comb begin
		item_in.cmd              = vpsr_pkg::cmd_t'(s_tuser[2:0]);
		item_in.relative         = s_tuser[3];
		item_in.first_of_command = s_tuser[4];
		item_in.path_start       = s_tuser[5];
		item_in.ctrl_one_x       = s_tdata[31:0];
		item_in.ctrl_one_y       = s_tdata[63:32];
		item_in.ctrl_two_x       = s_tdata[95:64];
		item_in.ctrl_two_y       = s_tdata[127:96];
		item_in.end_x            = s_tdata[159:128];
		item_in.end_y            = s_tdata[191:160];
	end

	// Handshake control
	assign s2_load  = !valid_s2 || m_tready;
	assign adv      = valid_s1 && s2_load;
	assign s_tready = !valid_s1 || s2_load;
	assign s_take   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (s2_load)
				valid_s2 <= valid_s1;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (s_take)
			item_s1 <= item_in;
		if (adv)
			res_s2 <= res_c;
	end

	vpsr_resolve #(
		.COORD_BITS(COORD_BITS)
	) u_resolve (
		.item               (item_s1),
		.cur_x              (cur_x_q),
		.cur_y              (cur_y_q),
		.last_ctrl_x        (last_ctrl_x_q),
		.last_ctrl_y        (last_ctrl_y_q),
		.prev_was_curve     (prev_curve_q),
		.sub_start_x        (sub_x_q),
		.sub_start_y        (sub_y_q),
		.res                (res_c),
		.nxt_cur_x          (n_cur_x),
		.nxt_cur_y          (n_cur_y),
		.nxt_last_ctrl_x    (n_lcx),
		.nxt_last_ctrl_y    (n_lcy),
		.nxt_prev_was_curve (n_prev_curve),
		.nxt_sub_start_x    (n_sub_x),
		.nxt_sub_start_y    (n_sub_y)
	);

	// Path state, updated as each item moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q       <= '0;
			cur_y_q       <= '0;
			last_ctrl_x_q <= '0;
			last_ctrl_y_q <= '0;
			prev_curve_q  <= 1'b0;
			sub_x_q       <= '0;
			sub_y_q       <= '0;
		end else if (adv) begin
			cur_x_q       <= n_cur_x;
			cur_y_q       <= n_cur_y;
			last_ctrl_x_q <= n_lcx;
			last_ctrl_y_q <= n_lcy;
			prev_curve_q  <= n_prev_curve;
			sub_x_q       <= n_sub_x;
			sub_y_q       <= n_sub_y;
		end
	end

	// Pack the master item
	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.seg_kind;
	assign m_tdata  = {res_s2.abs_end_y, res_s2.abs_end_x, res_s2.abs_c2_y,
		res_s2.abs_c2_x, res_s2.abs_c1_y, res_s2.abs_c1_x};

	// Checks
	a_close_home: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item_s1.cmd == vpsr_pkg::CMD_CLOSE && !item_s1.path_start
		|=> cur_x_q == $past(sub_x_q) && cur_y_q == $past(sub_y_q))
		else $error("close did not return to subpath start");

	a_curve_flag: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (item_s1.cmd == vpsr_pkg::CMD_CUBIC || item_s1.cmd == vpsr_pkg::CMD_SMOOTH)
		|=> prev_curve_q)
		else $error("curve flag not set after cubic");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && m_tvalid && !m_tready)
		else $error("input stalled with room in the pipeline");

	a_adv_shows: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> m_tvalid)
		else $error("advanced item missing on output");

endmodule
`default_nettype wire

@@ design/vpsr_resolve.sv @@
// Combinational segment resolver: one coordinate group plus path state in,
// one absolute segment plus next path state out. Depends on vpsr_pkg.
`default_nettype none
module vpsr_resolve #(
	parameter int COORD_BITS = 32
) (
	input  vpsr_pkg::in_item_t        item,
	input  logic signed [COORD_BITS-1:0] cur_x,
	input  logic signed [COORD_BITS-1:0] cur_y,
	input  logic signed [COORD_BITS-1:0] last_ctrl_x,
	input  logic signed [COORD_BITS-1:0] last_ctrl_y,
	input  logic                         prev_was_curve,
	input  logic signed [COORD_BITS-1:0] sub_start_x,
	input  logic signed [COORD_BITS-1:0] sub_start_y,
	output vpsr_pkg::out_item_t       res,
	output logic signed [COORD_BITS-1:0] nxt_cur_x,
	output logic signed [COORD_BITS-1:0] nxt_cur_y,
	output logic signed [COORD_BITS-1:0] nxt_last_ctrl_x,
	output logic signed [COORD_BITS-1:0] nxt_last_ctrl_y,
	output logic                         nxt_prev_was_curve,
	output logic signed [COORD_BITS-1:0] nxt_sub_start_x,
	output logic signed [COORD_BITS-1:0] nxt_sub_start_y
);

	typedef logic signed [COORD_BITS-1:0] coord_t;

	coord_t cx, cy, lcx, lcy, ssx, ssy;
	logic   pwc;
	coord_t ox, oy;
	coord_t in_c1x, in_c1y, in_c2x, in_c2y, in_ex, in_ey;
	coord_t c1x, c1y, c2x, c2y, ex, ey;
	vpsr_pkg::seg_kind_t kind;

	// Path start wipes the stored points before this group is used
	always_comb begin
		cx  = item.path_start ? '0 : cur_x;
		cy  = item.path_start ? '0 : cur_y;
		lcx = item.path_start ? '0 : last_ctrl_x;
		lcy = item.path_start ? '0 : last_ctrl_y;
		pwc = item.path_start ? 1'b0 : prev_was_curve;
		ssx = item.path_start ? '0 : sub_start_x;
		ssy = item.path_start ? '0 : sub_start_y;
	end

	// Widen or narrow the 32-bit fields to the internal coordinate width
	assign in_c1x = coord_t'(item.ctrl_one_x);
	assign in_c1y = coord_t'(item.ctrl_one_y);
	assign in_c2x = coord_t'(item.ctrl_two_x);
	assign in_c2y = coord_t'(item.ctrl_two_y);
	assign in_ex  = coord_t'(item.end_x);
	assign in_ey  = coord_t'(item.end_y);

	// Offset for relative groups
	assign ox = item.relative ? cx : '0;
	assign oy = item.relative ? cy : '0;

	// Per-command resolution
	always_comb begin
		c1x = '0;
		c1y = '0;
		c2x = '0;
		c2y = '0;
		ex = ssx;
		ey = ssy;
		kind = vpsr_pkg::SEG_CLOSE;
		nxt_last_ctrl_x = lcx;
		nxt_last_ctrl_y = lcy;
		nxt_prev_was_curve = 1'b0;
		nxt_sub_start_x = ssx;
		nxt_sub_start_y = ssy;
		unique case (item.cmd)
			vpsr_pkg::CMD_MOVE, vpsr_pkg::CMD_LINE: begin
				ex = in_ex + ox;
				ey = in_ey + oy;
				kind = vpsr_pkg::SEG_LINE;
				// first group of a move opens a subpath
				if (item.cmd == vpsr_pkg::CMD_MOVE && item.first_of_command) begin
					kind = vpsr_pkg::SEG_MOVE;
					nxt_sub_start_x = ex;
					nxt_sub_start_y = ey;
				end
			end
			vpsr_pkg::CMD_HORIZ: begin
				ex = in_ex + ox;
				ey = cy;
				kind = vpsr_pkg::SEG_LINE;
			end
			vpsr_pkg::CMD_VERT: begin
				ex = cx;
				ey = in_ey + oy;
				kind = vpsr_pkg::SEG_LINE;
			end
			vpsr_pkg::CMD_CUBIC, vpsr_pkg::CMD_SMOOTH: begin
				if (item.cmd == vpsr_pkg::CMD_CUBIC) begin
					c1x = in_c1x + ox;
					c1y = in_c1y + oy;
				end else if (pwc) begin
					// reflect last control point about the current point
					c1x = (cx <<< 1) - lcx;
					c1y = (cy <<< 1) - lcy;
				end else begin
					c1x = cx;
					c1y = cy;
				end
				c2x = in_c2x + ox;
				c2y = in_c2y + oy;
				ex = in_ex + ox;
				ey = in_ey + oy;
				kind = vpsr_pkg::SEG_CUBIC;
				nxt_last_ctrl_x = c2x;
				nxt_last_ctrl_y = c2y;
				nxt_prev_was_curve = 1'b1;
			end
			default: begin
				// close, and the unused code: back to subpath start
				ex = ssx;
				ey = ssy;
				kind = vpsr_pkg::SEG_CLOSE;
			end
		endcase
	end

	assign nxt_cur_x = ex;
	assign nxt_cur_y = ey;

	// Result fields back to 32 bits, sign-extended or truncated
	always_comb begin
		res.seg_kind  = kind;
		res.abs_c1_x  = vpsr_pkg::field_t'(c1x);
		res.abs_c1_y  = vpsr_pkg::field_t'(c1y);
		res.abs_c2_x  = vpsr_pkg::field_t'(c2x);
		res.abs_c2_y  = vpsr_pkg::field_t'(c2y);
		res.abs_end_x = vpsr_pkg::field_t'(ex);
		res.abs_end_y = vpsr_pkg::field_t'(ey);
	end

endmodule
`default_nettype wire

@@ dv/vector_path_segment_resolver_top_tb.sv @@
// Testbench for vector_path_segment_resolver_top: drives coordinate groups on the slave
// stream and checks every absolute segment against a path-state predictor in a scoreboard.
// Depends on vpsr_pkg and the resolver RTL.
`default_nettype none
module vector_path_segment_resolver_top_tb;

	// Command code outside the enum; the block resolves it as a close
	localparam logic [2:0] CMD_SPARE = 3'd7;
	localparam int RANDOM_GROUPS = 1050;
	localparam int DRAIN_LIMIT = 2000;
	localparam int RUN_LIMIT = 4000000;

	typedef struct packed {
		logic [2:0]       cmd;
		logic             rel;
		logic             first;
		logic             clear;
		vpsr_pkg::field_t c1x, c1y, c2x, c2y, ex, ey;
	} group_t;

	typedef struct packed {
		vpsr_pkg::seg_kind_t kind;
		vpsr_pkg::field_t    c1x, c1y, c2x, c2y, ex, ey;
	} seg_t;

	// Path state tracker and expected segment queue
	class path_scoreboard;
		vpsr_pkg::field_t cur_x, cur_y, ctl_x, ctl_y, start_x, start_y;
		logic   was_curve;
		seg_t   expected_q[$];
		int     mismatches, checked, accepted;
		int     kind_count[4];

		function new();
			clear_state();
			mismatches = 0;
			checked = 0;
			accepted = 0;
			foreach (kind_count[i]) kind_count[i] = 0;
		endfunction

		function void clear_state();
			cur_x = '0;
			cur_y = '0;
			ctl_x = '0;
			ctl_y = '0;
			start_x = '0;
			start_y = '0;
			was_curve = 1'b0;
		endfunction

		// Resolve one accepted group into its absolute segment
		function void note_group(group_t g);
			vpsr_pkg::field_t off_x, off_y, nx, ny;
			seg_t s;
			if (g.clear) clear_state();
			off_x = g.rel ? cur_x : '0;
			off_y = g.rel ? cur_y : '0;
			s = '0;
			case (g.cmd)
				vpsr_pkg::CMD_MOVE, vpsr_pkg::CMD_LINE: begin
					nx = g.ex + off_x;
					ny = g.ey + off_y;
					s.kind = vpsr_pkg::SEG_LINE;
					// first pair of a move opens a subpath, later pairs are lines
					if (g.cmd == vpsr_pkg::CMD_MOVE && g.first) begin
						s.kind = vpsr_pkg::SEG_MOVE;
						start_x = nx;
						start_y = ny;
					end
					was_curve = 1'b0;
				end
				vpsr_pkg::CMD_HORIZ: begin
					nx = g.ex + off_x;
					ny = cur_y;
					s.kind = vpsr_pkg::SEG_LINE;
					was_curve = 1'b0;
				end
				vpsr_pkg::CMD_VERT: begin
					nx = cur_x;
					ny = g.ey + off_y;
					s.kind = vpsr_pkg::SEG_LINE;
					was_curve = 1'b0;
				end
				vpsr_pkg::CMD_CUBIC, vpsr_pkg::CMD_SMOOTH: begin
					if (g.cmd == vpsr_pkg::CMD_CUBIC) begin
						s.c1x = g.c1x + off_x;
						s.c1y = g.c1y + off_y;
					end else if (was_curve) begin
						// reflect last control point about the current point
						s.c1x = (cur_x << 1) - ctl_x;
						s.c1y = (cur_y << 1) - ctl_y;
					end else begin
						s.c1x = cur_x;
						s.c1y = cur_y;
					end
					s.c2x = g.c2x + off_x;
					s.c2y = g.c2y + off_y;
					nx = g.ex + off_x;
					ny = g.ey + off_y;
					ctl_x = s.c2x;
					ctl_y = s.c2y;
					was_curve = 1'b1;
					s.kind = vpsr_pkg::SEG_CUBIC;
				end
				default: begin
					// close, and the spare code
					nx = start_x;
					ny = start_y;
					was_curve = 1'b0;
					s.kind = vpsr_pkg::SEG_CLOSE;
				end
			endcase
			cur_x = nx;
			cur_y = ny;
			s.ex = nx;
			s.ey = ny;
			expected_q.insert(expected_q.size(), s);
			accepted++;
		endfunction

		function void check_segment(seg_t got);
			seg_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("segment with nothing expected: kind %0d end %h %h",
						got.kind, got.ex, got.ey);
				return;
			end
			want = expected_q.pop_front();
			checked++;
			kind_count[want.kind]++;
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("segment %0d mismatch at %0t", checked, $realtime);
					$display("  want kind %0d c1 %h %h c2 %h %h end %h %h", want.kind,
						want.c1x, want.c1y, want.c2x, want.c2y, want.ex, want.ey);
					$display("  got  kind %0d c1 %h %h c2 %h %h end %h %h", got.kind,
						got.c1x, got.c1y, got.c2x, got.c2y, got.ex, got.ey);
				end
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void close_out();
			if (expected_q.size() != 0) begin
				$display("%0d segments never arrived", expected_q.size());
				mismatches += expected_q.size();
			end
		endfunction
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [vpsr_pkg::TDATA_BITS-1:0] s_tdata = '0;
	logic [5:0]                      s_tuser = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [vpsr_pkg::TDATA_BITS-1:0] m_tdata;
	logic [1:0]                      m_tuser;

	path_scoreboard sb;
	bit             calm = 1'b0;
	int             sent = 0;
	group_t         mon_g;
	seg_t           mon_s;

	vector_path_segment_resolver_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#RUN_LIMIT;
		$display("DONE: errors detected");
		$finish;
	end

	// Idle length: mostly none or short, now and then long; none in calm stretches
	function automatic int gap_len();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic vpsr_pkg::field_t rand_coord();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return vpsr_pkg::field_t'($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
		if (r < 85) return vpsr_pkg::field_t'($urandom);
		case ($urandom_range(0, 4))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return 32'sh0000_0000;
			3: return 32'shFFFF_FFFF;
			default: return 32'sh0001_0000;
		endcase
	endfunction

	function automatic group_t make_group(logic [2:0] cmd, logic first, logic clear);
		group_t g;
		g.cmd = cmd;
		g.rel = 1'($urandom_range(0, 1));
		g.first = first;
		g.clear = clear;
		g.c1x = rand_coord();
		g.c1y = rand_coord();
		g.c2x = rand_coord();
		g.c2y = rand_coord();
		g.ex = rand_coord();
		g.ey = rand_coord();
		return g;
	endfunction

	task automatic send_group(group_t g);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= {g.clear, g.first, g.rel, g.cmd};
		s_tdata <= {g.ey, g.ex, g.c2y, g.c2x, g.c1y, g.c1x};
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	task automatic dir_group(logic [2:0] cmd, logic rel, logic first, logic clear,
			vpsr_pkg::field_t c1x, vpsr_pkg::field_t c1y, vpsr_pkg::field_t c2x,
			vpsr_pkg::field_t c2y, vpsr_pkg::field_t ex, vpsr_pkg::field_t ey);
		group_t g;
		g = '{cmd, rel, first, clear, c1x, c1y, c2x, c2y, ex, ey};
		send_group(g);
	endtask

	// One well-formed path: opening move, implicit lines, then mixed commands
	task automatic run_path();
		int n_cmds, n_groups;
		logic [2:0] c;
		send_group(make_group(vpsr_pkg::CMD_MOVE, 1'b1, $urandom_range(0, 3) != 0));
		repeat ($urandom_range(0, 2)) send_group(make_group(vpsr_pkg::CMD_MOVE, 1'b0, 1'b0));
		n_cmds = $urandom_range(2, 8);
		repeat (n_cmds) begin
			c = 3'($urandom_range(0, 6));
			n_groups = (c == vpsr_pkg::CMD_CLOSE) ? 1 : $urandom_range(1, 3);
			for (int i = 0; i < n_groups; i++)
				send_group(make_group(c, i == 0, 1'b0));
		end
	endtask

	// Observe both handshakes; input first so the expectation is always queued in time
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (s_tvalid && s_tready) begin
				mon_g.cmd = s_tuser[2:0];
				mon_g.rel = s_tuser[3];
				mon_g.first = s_tuser[4];
				mon_g.clear = s_tuser[5];
				{mon_g.ey, mon_g.ex, mon_g.c2y, mon_g.c2x, mon_g.c1y, mon_g.c1x} = s_tdata;
				sb.note_group(mon_g);
			end
			if (m_tvalid && m_tready) begin
				mon_s.kind = vpsr_pkg::seg_kind_t'(m_tuser);
				{mon_s.ey, mon_s.ex, mon_s.c2y, mon_s.c2x, mon_s.c1y, mon_s.c1x} = m_tdata;
				sb.check_segment(mon_s);
			end
		end
	end

	// Receiver backpressure
	initial begin
		int run, gap;
		wait (arst_n === 1'b1);
		forever begin
			run = $urandom_range(1, 12);
			m_tready <= 1'b1;
			repeat (run) @(posedge clk);
			gap = gap_len();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	initial begin
		int directed, waited;
		bit paused;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, every command, wrap, reflection, ignored fields
		dir_group(vpsr_pkg::CMD_MOVE, 0, 1, 1, 32'sh1234_5678, -1, 5, 6,
			32'sh7FFF_FFFF, 32'sh8000_0000);
		dir_group(vpsr_pkg::CMD_MOVE, 1, 0, 0, 0, 0, 0, 0, 1, -1);
		dir_group(vpsr_pkg::CMD_LINE, 1, 1, 0, -1, -1, -1, -1,
			32'sh8000_0000, 32'sh7FFF_FFFF);
		dir_group(vpsr_pkg::CMD_HORIZ, 0, 0, 0, 7, 7, 7, 7, 32'sh0003_0000, 32'shDEAD_BEEF);
		dir_group(vpsr_pkg::CMD_VERT, 1, 1, 0, 9, 9, 9, 9, 32'shCAFE_F00D, 32'shFFFE_0000);
		dir_group(vpsr_pkg::CMD_CUBIC, 0, 1, 0, 32'sh7FFF_FFFF, 32'sh8000_0000,
			32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0001_0000, 32'sh0002_0000);
		dir_group(vpsr_pkg::CMD_SMOOTH, 1, 1, 0, 32'sh5555_5555, 32'shAAAA_AAAA,
			32'sh0001_8000, -32'sh0000_4000, 32'sh0002_0000, 32'sh0001_0000);
		dir_group(vpsr_pkg::CMD_SMOOTH, 0, 0, 0, 0, 0, 32'sh7FFF_0000, 32'sh8001_0000,
			32'sh4000_0000, -32'sh4000_0000);
		dir_group(vpsr_pkg::CMD_CLOSE, 1, 1, 0, -1, -1, -1, -1, -1, -1);
		dir_group(vpsr_pkg::CMD_SMOOTH, 1, 1, 0, 3, 3, 32'sh0000_8000, 32'sh0000_8000, 1, 1);
		dir_group(vpsr_pkg::CMD_CUBIC, 1, 0, 0, -1, 1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			32'sh8000_0000, 32'sh8000_0000);
		dir_group(vpsr_pkg::CMD_LINE, 0, 0, 0, 0, 0, 0, 0, 32'sh0010_0000, 32'sh0020_0000);
		dir_group(CMD_SPARE, 1, 1, 0, 1, 2, 3, 4, 5, 6);
		dir_group(vpsr_pkg::CMD_MOVE, 1, 1, 0, 0, 0, 0, 0, 32'sh0000_1000, -32'sh0000_1000);
		dir_group(vpsr_pkg::CMD_HORIZ, 1, 1, 0, 0, 0, 0, 0, -32'sh0001_0000, 32'sh1111_1111);
		dir_group(vpsr_pkg::CMD_VERT, 0, 0, 0, 0, 0, 0, 0, 32'sh2222_2222, 32'sh7FFF_FFFF);
		dir_group(vpsr_pkg::CMD_CUBIC, 0, 1, 0, 1, 1, 2, 2, 3, 3);
		dir_group(vpsr_pkg::CMD_LINE, 1, 1, 1, 0, 0, 0, 0, 32'sh0005_0000, 32'sh0006_0000);
		dir_group(vpsr_pkg::CMD_CUBIC, 0, 1, 0, 4, 4, 8, 8, 16, 16);
		dir_group(vpsr_pkg::CMD_SMOOTH, 0, 1, 1, -1, -1, 32'sh0001_0000, 32'sh0001_0000, 2, 2);
		dir_group(vpsr_pkg::CMD_CLOSE, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		dir_group(vpsr_pkg::CMD_MOVE, 0, 0, 0, -1, -1, -1, -1, -1, -1);
		directed = sent;

		// Random paths with occasional noise and calm stretches
		paused = 1'b0;
		while (sent < directed + RANDOM_GROUPS) begin
			if ($urandom_range(0, 7) == 0) calm = !calm;
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 3))
					send_group(make_group(3'($urandom_range(0, 7)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
			end else begin
				run_path();
			end
			// hold the sender until the pipeline has fully drained
			if (!paused && sent > directed + 400) begin
				paused = 1'b1;
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (sb.pending() != 0) @(posedge clk);
			end
		end
		s_tvalid <= 1'b0;

		waited = 0;
		while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
		sb.close_out();

		$display("%0d groups resolved, %0d segments checked", sb.accepted, sb.checked);
		$display("segment mix: %0d move, %0d line, %0d cubic, %0d close; %0d mismatches",
			sb.kind_count[vpsr_pkg::SEG_MOVE], sb.kind_count[vpsr_pkg::SEG_LINE],
			sb.kind_count[vpsr_pkg::SEG_CUBIC], sb.kind_count[vpsr_pkg::SEG_CLOSE],
			sb.mismatches);
		if (sb.mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
`default_nettype wire

@@ vector_path_segment_resolver_top.f @@
design/vpsr_pkg.sv
design/vpsr_resolve.sv
design/vector_path_segment_resolver_top.sv
dv/vector_path_segment_resolver_top_tb.sv
